// ===== rtl/ufbb_pkg.sv =====
// ----------------------------------------------------------------------------
// ufbb_pkg
// Shared types and constants for the usable frame bitmap builder.
// ----------------------------------------------------------------------------
`default_nettype none

package ufbb_pkg;

   localparam int DATA_W  = 32;
   localparam int MODE_W  = 2;
   localparam int INDEX_W = 15;
   localparam int WRAP_W  = 20;

   localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

   localparam logic [DATA_W-1:0] TYPE_AVAILABLE  = 32'd1;
   localparam logic [WRAP_W-1:0] WRAP_LAST_FRAME = 20'hFFFFF;

   // One bitmap word holds both maps for the same 32 frames
   typedef struct packed {
      logic [DATA_W-1:0] reserved;
      logic [DATA_W-1:0] available;
   } map_word_type;

endpackage

`default_nettype wire

// ===== rtl/ufbb_map_ram.sv =====
// ----------------------------------------------------------------------------
// ufbb_map_ram
// Single write, single read bitmap store with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ufbb_map_ram #(
   parameter int DEPTH  = 32768,
   parameter int ADDR_W = 15
) (
   input  wire                     clock,
   input  wire                     wr_en,
   input  wire [ADDR_W-1:0]        wr_addr,
   input  wire ufbb_pkg::map_word_type wr_data,
   input  wire                     rd_en,
   input  wire [ADDR_W-1:0]        rd_addr,
   output ufbb_pkg::map_word_type  rd_data
);
   import ufbb_pkg::*;

   map_word_type mem [DEPTH];
   map_word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/ufbb_range.sv =====
// ----------------------------------------------------------------------------
// ufbb_range
// Turns a region into a clipped frame range over three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module ufbb_range #(
   parameter int FRAME_COUNT = 1048576,
   parameter int PAGE_BYTES  = 4096,
   parameter int FIDX_W      = 20
) (
   input  wire                        clock,
   input  wire                        load,
   input  wire                        step_next,
   input  wire                        step_last,
   input  wire [ufbb_pkg::DATA_W-1:0] region_base,
   input  wire [ufbb_pkg::DATA_W-1:0] region_length,
   input  wire [ufbb_pkg::DATA_W-1:0] region_type,
   output logic                       avail,
   output logic                       empty,
   output logic [FIDX_W-1:0]          lo_frame,
   output logic [FIDX_W-1:0]          hi_frame
);
   import ufbb_pkg::*;

   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int NEXT_W     = DATA_W + 1 - PAGE_SHIFT;
   localparam int CMP_W      = ((NEXT_W > WRAP_W) ? NEXT_W : WRAP_W) + 1;
   localparam logic [DATA_W-1:0] LOW_MASK  = DATA_W'(PAGE_BYTES - 1);
   localparam logic [CMP_W-1:0]  FRAME_LIM = CMP_W'(FRAME_COUNT);

   logic              avail_ff;
   logic [NEXT_W-1:0] first_ff;
   logic [DATA_W-1:0] end_ff;
   logic [NEXT_W-1:0] next_ff;
   logic [FIDX_W-1:0] last_ff;
   logic              empty_ff;

   logic              avail_in;
   logic [NEXT_W-1:0] first_in;
   logic [NEXT_W-1:0] next_in;
   logic [CMP_W-1:0]  last_raw;
   logic [CMP_W-1:0]  last_clip;

   // Available regions round inward, everything else outward
   always_comb begin
      avail_in = (region_type == TYPE_AVAILABLE);
      first_in = NEXT_W'(region_base >> PAGE_SHIFT)
               + NEXT_W'(avail_in && ((region_base & LOW_MASK) != '0));
      next_in  = NEXT_W'(end_ff >> PAGE_SHIFT)
               + NEXT_W'(!avail_ff && ((end_ff & LOW_MASK) != '0));
      if (next_ff == '0) begin
         last_raw = CMP_W'(WRAP_LAST_FRAME);
      end else begin
         last_raw = CMP_W'(next_ff) - CMP_W'(1);
      end
      if (last_raw >= FRAME_LIM) begin
         last_clip = FRAME_LIM - CMP_W'(1);
      end else begin
         last_clip = last_raw;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         avail_ff <= avail_in;
         first_ff <= first_in;
         end_ff   <= region_base + region_length;
      end
      if (step_next) begin
         next_ff <= next_in;
      end
      if (step_last) begin
         last_ff  <= FIDX_W'(last_clip);
         empty_ff <= (CMP_W'(first_ff) > last_clip);
      end
   end

   assign avail    = avail_ff;
   assign empty    = empty_ff;
   assign lo_frame = FIDX_W'(first_ff);
   assign hi_frame = last_ff;

endmodule

`default_nettype wire

// ===== rtl/usable_frame_bitmap_builder.sv =====
// ----------------------------------------------------------------------------
// usable_frame_bitmap_builder
// Builds available and reserved page-frame maps from memory-map regions and
// returns usable words (available and not reserved).
// ----------------------------------------------------------------------------
// Add beat: ST_RANGE_NEXT, ST_RANGE_LAST, then ST_FILL over each bitmap word the
//   clipped range covers (up to ceil(FRAME_COUNT/32)); req_ready returns after.
// Read beat: result valid when the rsp register is free; req_ready back with it.
// Clear beat and reset: a clearing pass over all ceil(FRAME_COUNT/32) map words
//   (32768 by default), one map word a cycle, with req_ready low throughout.
// Reset is synchronous, active high; results are offered through a register.
`default_nettype none

module usable_frame_bitmap_builder #(
   parameter int FRAME_COUNT = 1048576,
   parameter int PAGE_BYTES  = 4096
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_ready,
   input  wire [ufbb_pkg::MODE_W-1:0]  req_mode,
   input  wire [ufbb_pkg::DATA_W-1:0]  req_region_base,
   input  wire [ufbb_pkg::DATA_W-1:0]  req_region_length,
   input  wire [ufbb_pkg::DATA_W-1:0]  req_region_type,
   input  wire [ufbb_pkg::INDEX_W-1:0] req_word_index,
   output logic                        rsp_valid,
   input  wire                         rsp_ready,
   output logic [ufbb_pkg::DATA_W-1:0] rsp_usable_word
);
   import ufbb_pkg::*;

   localparam int FIDX_W    = $clog2(FRAME_COUNT);
   localparam int WORD_W    = FIDX_W - 5;
   localparam int MAP_DEPTH = (FRAME_COUNT + 31) / 32;
   localparam logic [WORD_W-1:0]  LAST_WORD = WORD_W'(MAP_DEPTH - 1);
   localparam logic [INDEX_W:0]   DEPTH_LIM = (INDEX_W + 1)'(MAP_DEPTH);

   typedef enum logic [6:0] {
      ST_CLEAR      = 7'b0000001,
      ST_IDLE       = 7'b0000010,
      ST_RANGE_NEXT = 7'b0000100,
      ST_RANGE_LAST = 7'b0001000,
      ST_FILL       = 7'b0010000,
      ST_READ       = 7'b0100000,
      ST_RESP       = 7'b1000000
   } state_type;

   state_type            state_ff, state_in;
   logic [WORD_W-1:0]    word_ff, word_in;
   logic [INDEX_W-1:0]   read_idx_ff;
   logic                 pend_valid_ff, pend_valid_in;
   logic [WORD_W-1:0]    pend_addr_ff;
   logic [DATA_W-1:0]    pend_mask_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]    rsp_word_ff;

   logic                 accept;
   logic                 range_load;
   logic                 range_avail;
   logic                 range_empty;
   logic [FIDX_W-1:0]    lo_frame;
   logic [FIDX_W-1:0]    hi_frame;
   logic [WORD_W-1:0]    first_word;
   logic [WORD_W-1:0]    last_word;
   logic [4:0]           lo_bit;
   logic [4:0]           hi_bit;
   logic [DATA_W-1:0]    fill_mask;
   logic                 read_in_map;
   logic                 rsp_load;

   logic                 wr_en;
   logic [WORD_W-1:0]    wr_addr;
   map_word_type         wr_data;
   logic                 rd_en;
   logic [WORD_W-1:0]    rd_addr;
   map_word_type         rd_data;

   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign range_load = accept && (req_mode == MODE_ADD);

   ufbb_range #(
      .FRAME_COUNT (FRAME_COUNT),
      .PAGE_BYTES  (PAGE_BYTES),
      .FIDX_W      (FIDX_W)
   ) u_range (
      .clock         (clock),
      .load          (range_load),
      .step_next     (state_ff == ST_RANGE_NEXT),
      .step_last     (state_ff == ST_RANGE_LAST),
      .region_base   (req_region_base),
      .region_length (req_region_length),
      .region_type   (req_region_type),
      .avail         (range_avail),
      .empty         (range_empty),
      .lo_frame      (lo_frame),
      .hi_frame      (hi_frame)
   );

   ufbb_map_ram #(
      .DEPTH  (MAP_DEPTH),
      .ADDR_W (WORD_W)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Partial masks on the first and last word of the range
   always_comb begin
      first_word = lo_frame[FIDX_W-1:5];
      last_word  = hi_frame[FIDX_W-1:5];
      lo_bit     = (word_ff == first_word) ? lo_frame[4:0] : 5'd0;
      hi_bit     = (word_ff == last_word) ? hi_frame[4:0] : 5'd31;
      fill_mask  = ({DATA_W{1'b1}} >> (5'd31 - hi_bit)) & ({DATA_W{1'b1}} << lo_bit);
   end

   assign read_in_map = ((INDEX_W + 1)'(read_idx_ff) < DEPTH_LIM);
   assign rsp_load    = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_ready);

   // Memory ports: clearing owns the write port, else the pending fill write
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = word_ff;
      wr_en   = 1'b0;
      wr_addr = pend_addr_ff;
      wr_data = rd_data;
      if (state_ff == ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = word_ff;
         wr_data = '0;
      end else if (pend_valid_ff) begin
         wr_en = 1'b1;
         if (range_avail) begin
            wr_data.available = rd_data.available | pend_mask_ff;
         end else begin
            wr_data.reserved = rd_data.reserved | pend_mask_ff;
         end
      end
      if ((state_ff == ST_FILL) && !range_empty) begin
         rd_en = 1'b1;
      end else if ((state_ff == ST_READ) && read_in_map) begin
         rd_en   = 1'b1;
         rd_addr = read_idx_ff[WORD_W-1:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      word_in       = word_ff;
      pend_valid_in = 1'b0;
      rsp_valid_in  = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
      unique case (state_ff)
         ST_CLEAR: begin
            word_in = word_ff + WORD_W'(1);
            if (word_ff == LAST_WORD) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_mode)
                  MODE_ADD: state_in = ST_RANGE_NEXT;
                  MODE_READ: state_in = ST_READ;
                  MODE_CLEAR: begin
                     state_in = ST_CLEAR;
                     word_in  = '0;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_RANGE_NEXT: state_in = ST_RANGE_LAST;
         ST_RANGE_LAST: state_in = ST_FILL;
         ST_FILL: begin
            if (range_empty) begin
               state_in = ST_IDLE;
            end else begin
               pend_valid_in = 1'b1;
               word_in       = word_ff + WORD_W'(1);
               if (word_ff == last_word) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_READ: state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // Start the fill at the first word once the range has settled
      if (state_ff == ST_RANGE_LAST) begin
         word_in = first_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         word_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         word_ff       <= word_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         read_idx_ff <= req_word_index;
      end
      if (state_ff == ST_FILL) begin
         pend_addr_ff <= word_ff;
         pend_mask_ff <= fill_mask;
      end
      if (rsp_load) begin
         rsp_word_ff <= read_in_map ? (rd_data.available & ~rd_data.reserved) : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_usable_word = rsp_word_ff;

endmodule

`default_nettype wire
